// ===== sv/dtc_pkg.sv =====
`default_nettype none

package dtc_pkg;

	// Table size and time width.
	localparam int NUM_CHANNELS = 16;
	localparam int CH_BITS      = 4;
	localparam int TIME_BITS    = 32;
	localparam int CNT_BITS     = 5;

	// Half of the time range, the limit of the wrap-safe "in the past" test.
	localparam logic [TIME_BITS-1:0] HALF_RANGE = {1'b1, {(TIME_BITS-1){1'b0}}};

	// Firing counter saturates here.
	localparam logic [15:0] FIRE_MAX = 16'hFFFF;

	// Command codes.
	localparam logic [2:0] FN_CHECK     = 3'd0;
	localparam logic [2:0] FN_START     = 3'd1;
	localparam logic [2:0] FN_STOP      = 3'd2;
	localparam logic [2:0] FN_PAUSE     = 3'd3;
	localparam logic [2:0] FN_RESUME    = 3'd4;
	localparam logic [2:0] FN_AGAIN     = 3'd5;
	localparam logic [2:0] FN_SET_DELAY = 3'd6;
	localparam logic [2:0] FN_CONFIGURE = 3'd7;

	// Channel status codes.
	localparam logic [1:0] ST_STOPPED = 2'd0;
	localparam logic [1:0] ST_RUNNING = 2'd1;
	localparam logic [1:0] ST_PAUSED  = 2'd2;
	localparam logic [1:0] ST_UNUSED  = 2'd3;

endpackage

`default_nettype wire

// ===== sv/deferred_timer_channels.sv =====
// Channel   Signals                                        Direction  Handshake
// request   func channel now delay_value autorepeat_flag   in         start, busy
//           has_action start_now run_post permit_rearm
// result    channel_status remaining_time fire_count       out        done (one cycle)
//
// A request is taken when start is high and busy is low; exactly one result follows.
// Check, start, stop, resume, set delay and configure pass through the load, command and finish
// states. A restart (an again, or autorepeat after expiry or stop) runs the again states, an
// again on a channel that is not stopped only the first of them, and a pause adds the pause
// state. A catch-up of missed periods runs a shared 32-step restoring divider. The next request
// can be taken in the done cycle. Reset clears every channel to stopped at once. The receiver
// cannot stall: done is a single-cycle strobe.
`default_nettype none

module deferred_timer_channels
	import dtc_pkg::*;
(
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire  [2:0]                 func,
	input  wire  [CH_BITS-1:0]         channel,
	input  wire  [TIME_BITS-1:0]       now,
	input  wire  [TIME_BITS-1:0]       delay_value,
	input  wire                        autorepeat_flag,
	input  wire                        has_action,
	input  wire                        start_now,
	input  wire                        run_post,
	input  wire                        permit_rearm,
	output logic                       done,
	output logic [1:0]                 channel_status,
	output logic signed [TIME_BITS-1:0] remaining_time,
	output logic [15:0]                fire_count
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LOAD   = 4'd1;
	localparam logic [3:0] S_CMD    = 4'd2;
	localparam logic [3:0] S_AG1    = 4'd3;
	localparam logic [3:0] S_AG2    = 4'd4;
	localparam logic [3:0] S_AG3    = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_AG4    = 4'd7;
	localparam logic [3:0] S_AG5    = 4'd8;
	localparam logic [3:0] S_PAUSE  = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	// Saturating add of a firing count.
	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [32:0] n);
		logic [16:0] s;
		s = {1'b0, a} + n[16:0];
		if (n >= {17'd0, FIRE_MAX} || s > {1'b0, FIRE_MAX})
			return FIRE_MAX;
		return s[15:0];
	endfunction

	// Channel table.
	logic [1:0]           tab_st_q  [NUM_CHANNELS];
	logic [TIME_BITS-1:0] tab_bt_q  [NUM_CHANNELS];
	logic [TIME_BITS-1:0] tab_per_q [NUM_CHANNELS];
	logic [TIME_BITS-1:0] tab_pe_q  [NUM_CHANNELS];
	logic                 tab_rep_q [NUM_CHANNELS];
	logic                 tab_act_q [NUM_CHANNELS];

	logic [3:0]           state_q;

	// Captured request.
	logic [2:0]           func_q;
	logic [CH_BITS-1:0]   ch_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] dly_q;
	logic                 arep_q, hact_q, snow_q, post_q, allow_q;

	// Working copy of the addressed channel.
	logic [1:0]           st_q;
	logic [TIME_BITS-1:0] bt_q, per_q, pe_q;
	logic                 rep_q, act_q;

	// Again sequence and divider.
	logic                 ag_post_q;
	logic [TIME_BITS-1:0] ag_dly_q;
	logic [TIME_BITS-1:0] gap_q;
	logic                 small_q;
	logic [TIME_BITS-1:0] num_q, dvd_q, dvs_q, rem_q, step_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [15:0]          fires_q;

	logic [TIME_BITS-1:0] elapsed;
	logic                 expired;
	logic                 in_past;
	logic                 ag_fire;
	logic [TIME_BITS:0]   trial;
	logic [3:0]           after_again;

	assign busy = (state_q != S_IDLE);

	// Elapsed time, also used for the remaining time, and the expiry test shared by check and pause.
	assign elapsed = now_q - bt_q;
	assign expired = (st_q == ST_RUNNING) && (elapsed >= per_q);

	// Wrap-safe test that the due time lies before now.
	assign in_past = (per_q != '0) && (gap_q != '0) && (gap_q <= HALF_RANGE);
	assign ag_fire = ag_post_q && act_q;

	// One restoring step: shifted remainder minus divisor.
	assign trial = {rem_q, dvd_q[TIME_BITS-1]} - {1'b0, dvs_q};

	assign after_again = (func_q == FN_PAUSE) ? S_PAUSE : S_FINISH;

	// Sequencer, working registers and outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				tab_st_q[i]  <= ST_STOPPED;
				tab_bt_q[i]  <= '0;
				tab_per_q[i] <= '0;
				tab_pe_q[i]  <= '0;
				tab_rep_q[i] <= 1'b0;
				tab_act_q[i] <= 1'b0;
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= func;
						ch_q    <= channel;
						now_q   <= now;
						dly_q   <= delay_value;
						arep_q  <= autorepeat_flag;
						hact_q  <= has_action;
						snow_q  <= start_now;
						post_q  <= run_post;
						allow_q <= permit_rearm;
						fires_q <= '0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					st_q    <= tab_st_q[ch_q];
					bt_q    <= tab_bt_q[ch_q];
					per_q   <= tab_per_q[ch_q];
					pe_q    <= tab_pe_q[ch_q];
					rep_q   <= tab_rep_q[ch_q];
					act_q   <= tab_act_q[ch_q];
					state_q <= S_CMD;
				end
				S_CMD: begin
					case (func_q)
						FN_CHECK, FN_PAUSE: begin
							state_q <= after_again;
							if (expired) begin
								st_q <= ST_STOPPED;
								if (act_q)
									fires_q <= sat_add(fires_q, 33'd1);
								if (rep_q) begin
									ag_post_q <= 1'b1;
									ag_dly_q  <= '0;
									state_q   <= S_AG1;
								end
							end
						end
						FN_START: begin
							if (dly_q != '0)
								per_q <= dly_q;
							bt_q    <= now_q;
							st_q    <= ST_RUNNING;
							state_q <= S_FINISH;
						end
						FN_STOP: begin
							state_q <= S_FINISH;
							if (st_q != ST_STOPPED) begin
								st_q <= ST_STOPPED;
								if (post_q && act_q)
									fires_q <= sat_add(fires_q, 33'd1);
								if (allow_q && rep_q) begin
									ag_post_q <= 1'b1;
									ag_dly_q  <= '0;
									state_q   <= S_AG1;
								end
							end
						end
						FN_RESUME: begin
							if (st_q == ST_PAUSED) begin
								bt_q <= now_q - pe_q;
								st_q <= ST_RUNNING;
							end
							state_q <= S_FINISH;
						end
						FN_AGAIN: begin
							ag_post_q <= post_q;
							ag_dly_q  <= dly_q;
							state_q   <= S_AG1;
						end
						FN_SET_DELAY: begin
							per_q   <= dly_q;
							state_q <= S_FINISH;
						end
						default: begin
							per_q   <= dly_q;
							bt_q    <= now_q;
							pe_q    <= '0;
							rep_q   <= arep_q;
							act_q   <= hact_q;
							st_q    <= snow_q ? ST_RUNNING : ST_STOPPED;
							state_q <= S_FINISH;
						end
					endcase
				end
				// Again: if stopped, advance by the old period and take the new one when it is nonzero.
				S_AG1: begin
					if (st_q != ST_STOPPED) begin
						state_q <= after_again;
					end else begin
						bt_q <= bt_q + per_q;
						if (ag_dly_q != '0)
							per_q <= ag_dly_q;
						state_q <= S_AG2;
					end
				end
				S_AG2: begin
					gap_q   <= now_q - bt_q - per_q;
					state_q <= S_AG3;
				end
				// Decide on catch-up and set up the divider.
				S_AG3: begin
					if (in_past) begin
						if (!rep_q) begin
							if (ag_fire)
								fires_q <= sat_add(fires_q, 33'd1);
							state_q <= after_again;
						end else begin
							small_q <= (per_q <= HALF_RANGE);
							if (per_q <= HALF_RANGE) begin
								num_q <= gap_q - 1'b1;
								dvd_q <= gap_q - 1'b1;
								dvs_q <= per_q;
							end else begin
								num_q <= HALF_RANGE - gap_q;
								dvd_q <= HALF_RANGE - gap_q;
								dvs_q <= '0 - per_q;
							end
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_DIV;
						end
					end else begin
						st_q    <= ST_RUNNING;
						state_q <= after_again;
					end
				end
				// One quotient bit per cycle; the quotient shifts into dvd_q.
				S_DIV: begin
					if (!trial[TIME_BITS]) begin
						rem_q <= trial[TIME_BITS-1:0];
						dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[TIME_BITS-2:0], dvd_q[TIME_BITS-1]};
						dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(TIME_BITS - 1))
						state_q <= S_AG4;
				end
				// Count the missed expiries; n times the divisor is num - rem + divisor.
				S_AG4: begin
					if (ag_fire)
						fires_q <= sat_add(fires_q, {1'b0, dvd_q} + 33'd1);
					step_q  <= num_q - rem_q + dvs_q;
					state_q <= S_AG5;
				end
				S_AG5: begin
					bt_q    <= small_q ? (bt_q + step_q) : (bt_q - step_q);
					st_q    <= ST_RUNNING;
					state_q <= after_again;
				end
				S_PAUSE: begin
					if (st_q == ST_RUNNING) begin
						st_q <= ST_PAUSED;
						pe_q <= elapsed;
					end
					state_q <= S_FINISH;
				end
				// Write the channel back and present the result.
				S_FINISH: begin
					tab_st_q[ch_q]  <= st_q;
					tab_bt_q[ch_q]  <= bt_q;
					tab_per_q[ch_q] <= per_q;
					tab_pe_q[ch_q]  <= pe_q;
					tab_rep_q[ch_q] <= rep_q;
					tab_act_q[ch_q] <= act_q;
					channel_status  <= st_q;
					remaining_time  <= per_q - elapsed;
					fire_count      <= fires_q;
					done            <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/dtc_checker.sv =====
`default_nettype none

module dtc_checker
	import dtc_pkg::*;
(
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire       done,
	input wire [1:0] channel_status
);

	// A result is shown only once the block is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// A taken request makes the block busy.
	a_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but block not busy");

	// Finishing an item always delivers its result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	// One result per request: strobes never come back to back.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// The unused status code is never reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (channel_status != ST_UNUSED))
		else $error("unused status code reported");

endmodule

bind deferred_timer_channels dtc_checker u_dtc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.channel_status (channel_status)
);

`default_nettype wire
